[design/http_status_line_parser_core_macros.svh]
// Assertion macros for the HTTP status line parser core.
`ifndef HTTP_STATUS_LINE_PARSER_CORE_MACROS_SVH
`define HTTP_STATUS_LINE_PARSER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define HSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsl assertion failed");

// next-cycle implication, disabled in reset
`define HSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsl assertion failed");

`endif

[design/hsl_pkg.sv]
// Types and constants for the HTTP status line parser core.
package hsl_pkg;

  localparam int unsigned VALUE_W = 14;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd999;

  localparam logic [31:0] TOTAL_LIMIT_RESET = 32'd81920;
  localparam logic [31:0] LINE_LIMIT_RESET  = 32'd8192;

  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    CFG_MAX_TOTAL = 2'd0,
    CFG_MAX_LINE  = 2'd1,
    CFG_STRICT    = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_MORE  = 2'd0,
    VERDICT_DONE  = 2'd1,
    VERDICT_ERROR = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_OVERFLOW = 3'd1,
    ERR_CONSTANT = 3'd2,
    ERR_STRICT   = 3'd3,
    ERR_VERSION  = 3'd4,
    ERR_STATUS   = 3'd5,
    ERR_STATE    = 3'd6
  } err_e;

  typedef enum logic [14:0] {
    PH_START        = 15'h0001,
    PH_H            = 15'h0002,
    PH_HT           = 15'h0004,
    PH_HTT          = 15'h0008,
    PH_HTTP         = 15'h0010,
    PH_FIRST_MAJOR  = 15'h0020,
    PH_MAJOR        = 15'h0040,
    PH_FIRST_MINOR  = 15'h0080,
    PH_MINOR        = 15'h0100,
    PH_FIRST_CODE   = 15'h0200,
    PH_CODE         = 15'h0400,
    PH_REASON_START = 15'h0800,
    PH_REASON       = 15'h1000,
    PH_ALMOST_DONE  = 15'h2000,
    PH_DONE         = 15'h4000
  } phase_e;

endpackage

[design/http_status_line_parser_core.sv]
// A byte's result is registered and valid in the cycle after it is accepted.
// Throughput: one byte per cycle unless a held result stalls in_ready_o; the
// decode and times-ten accumulate are combinational, parser state to result.
// Reset (async, active low) returns the parser to the start of a line,
// clears values, counts and the sticky error, and restores limit defaults.
module http_status_line_parser_core
  import hsl_pkg::*;
#(
  parameter int unsigned LIMIT_WIDTH = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [LIMIT_WIDTH-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             data_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             verdict_o,
  output logic [2:0]             error_code_o,
  output logic [VALUE_W-1:0]     version_major_o,
  output logic [VALUE_W-1:0]     version_minor_o,
  output logic [VALUE_W-1:0]     status_value_o,
  output logic                   reason_begin_o,
  output logic                   reason_end_o
);

`include "http_status_line_parser_core_macros.svh"

  localparam int unsigned CNT_W = LIMIT_WIDTH + 1;

  logic [LIMIT_WIDTH-1:0] max_total_q, max_line_q;
  logic                   strict_q;

  phase_e               phase_q, phase_d;
  err_e                 err_q, err_d, step_err;
  logic [VALUE_W-1:0]   major_q, major_d, minor_q, minor_d, code_q, code_d;
  logic [CNT_W-1:0]     total_q, total_d, line_q, line_d, total_inc, line_inc;

  logic                 out_valid_q;
  verdict_e             verdict_q, verdict_d;
  err_e                 ecode_q;
  logic [VALUE_W-1:0]   omajor_q, ominor_q, ocode_q;
  logic                 rb_q, rb_d, re_q, re_d;

  logic                 in_fire;
  logic                 is_digit;
  logic [VALUE_W-1:0]   digit;
  logic [VALUE_W-1:0]   major_acc, minor_acc, code_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_total_q <= TOTAL_LIMIT_RESET[LIMIT_WIDTH-1:0];
      max_line_q  <= LINE_LIMIT_RESET[LIMIT_WIDTH-1:0];
      strict_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_TOTAL: max_total_q <= cfg_data_i;
        CFG_MAX_LINE:  max_line_q  <= cfg_data_i;
        CFG_STRICT:    strict_q    <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  assign is_digit  = (data_byte_i >= CH_ZERO) && (data_byte_i <= CH_NINE);
  assign digit     = VALUE_W'(data_byte_i[3:0]);
  assign major_acc = (major_q << 3) + (major_q << 1) + digit;
  assign minor_acc = (minor_q << 3) + (minor_q << 1) + digit;
  assign code_acc  = (code_q << 3) + (code_q << 1) + digit;
  assign total_inc = total_q + CNT_W'(1);
  assign line_inc  = line_q + CNT_W'(1);

  always_comb begin
    phase_d   = phase_q;
    err_d     = err_q;
    major_d   = major_q;
    minor_d   = minor_q;
    code_d    = code_q;
    total_d   = total_q;
    line_d    = line_q;
    step_err  = ERR_NONE;
    verdict_d = VERDICT_MORE;
    rb_d      = 1'b0;
    re_d      = 1'b0;
    if (err_q != ERR_NONE) begin
      verdict_d = VERDICT_ERROR;
    end else begin
      total_d = total_inc;
      if (total_inc > {1'b0, max_total_q}) begin
        step_err = ERR_OVERFLOW;
      end else begin
        line_d = line_inc;
        if (line_inc > {1'b0, max_line_q}) step_err = ERR_OVERFLOW;
      end
      if (step_err == ERR_NONE) begin
        unique case (phase_q)
          PH_START: begin
            if (data_byte_i == CH_H) phase_d = PH_H;
            else if (data_byte_i != CH_CR && data_byte_i != CH_LF) step_err = ERR_CONSTANT;
          end
          PH_H: begin
            if (strict_q && data_byte_i != CH_T) step_err = ERR_STRICT;
            else phase_d = PH_HT;
          end
          PH_HT: begin
            if (strict_q && data_byte_i != CH_T) step_err = ERR_STRICT;
            else phase_d = PH_HTT;
          end
          PH_HTT: begin
            if (strict_q && data_byte_i != CH_P) step_err = ERR_STRICT;
            else phase_d = PH_HTTP;
          end
          PH_HTTP: begin
            if (strict_q && data_byte_i != CH_SLASH) step_err = ERR_STRICT;
            else phase_d = PH_FIRST_MAJOR;
          end
          PH_FIRST_MAJOR: begin
            if (!is_digit) begin
              step_err = ERR_VERSION;
            end else begin
              major_d = digit;
              phase_d = PH_MAJOR;
            end
          end
          PH_MAJOR: begin
            if (data_byte_i == CH_DOT) begin
              phase_d = PH_FIRST_MINOR;
            end else if (!is_digit) begin
              step_err = ERR_VERSION;
            end else begin
              major_d = major_acc;
              if (major_acc > VALUE_MAX) step_err = ERR_VERSION;
            end
          end
          PH_FIRST_MINOR: begin
            if (!is_digit) begin
              step_err = ERR_VERSION;
            end else begin
              minor_d = digit;
              phase_d = PH_MINOR;
            end
          end
          PH_MINOR: begin
            if (data_byte_i == CH_SP) begin
              phase_d = PH_FIRST_CODE;
            end else if (!is_digit) begin
              step_err = ERR_VERSION;
            end else begin
              minor_d = minor_acc;
              if (minor_acc > VALUE_MAX) step_err = ERR_VERSION;
            end
          end
          PH_FIRST_CODE: begin
            if (is_digit) begin
              code_d  = digit;
              phase_d = PH_CODE;
            end else if (data_byte_i != CH_SP) begin
              step_err = ERR_STATUS;
            end
          end
          PH_CODE: begin
            if (is_digit) begin
              code_d = code_acc;
              if (code_acc > VALUE_MAX) step_err = ERR_STATUS;
            end else if (data_byte_i == CH_SP) begin
              phase_d = PH_REASON_START;
            end else if (data_byte_i == CH_CR) begin
              phase_d = PH_ALMOST_DONE;
            end else if (data_byte_i == CH_LF) begin
              phase_d   = PH_DONE;
              verdict_d = VERDICT_DONE;
            end else begin
              step_err = ERR_STATUS;
            end
          end
          PH_REASON_START: begin
            if (data_byte_i == CH_CR) begin
              phase_d = PH_ALMOST_DONE;
            end else if (data_byte_i == CH_LF) begin
              phase_d   = PH_DONE;
              verdict_d = VERDICT_DONE;
            end else begin
              phase_d = PH_REASON;
              rb_d    = 1'b1;
            end
          end
          PH_REASON: begin
            if (data_byte_i == CH_CR) begin
              phase_d = PH_ALMOST_DONE;
              re_d    = 1'b1;
            end else if (data_byte_i == CH_LF) begin
              phase_d   = PH_DONE;
              re_d      = 1'b1;
              verdict_d = VERDICT_DONE;
            end
          end
          PH_ALMOST_DONE: begin
            if (strict_q && data_byte_i != CH_LF) begin
              step_err = ERR_STRICT;
            end else begin
              phase_d   = PH_DONE;
              verdict_d = VERDICT_DONE;
            end
          end
          default: step_err = ERR_STATE;
        endcase
      end
      if (step_err != ERR_NONE) begin
        err_d     = step_err;
        verdict_d = VERDICT_ERROR;
        rb_d      = 1'b0;
        re_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      err_q   <= ERR_NONE;
      major_q <= '0;
      minor_q <= '0;
      code_q  <= '0;
      total_q <= '0;
      line_q  <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      err_q   <= err_d;
      major_q <= major_d;
      minor_q <= minor_d;
      code_q  <= code_d;
      total_q <= total_d;
      line_q  <= line_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      verdict_q <= verdict_d;
      ecode_q   <= err_d;
      omajor_q  <= major_d;
      ominor_q  <= minor_d;
      ocode_q   <= code_d;
      rb_q      <= rb_d;
      re_q      <= re_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign verdict_o       = verdict_q;
  assign error_code_o    = ecode_q;
  assign version_major_o = omajor_q;
  assign version_minor_o = ominor_q;
  assign status_value_o  = ocode_q;
  assign reason_begin_o  = rb_q;
  assign reason_end_o    = re_q;

  `HSL_ASSERT_NEXT(a_err_sticky, clk_i, rst_ni, err_q != ERR_NONE, err_q == $past(err_q))
  `HSL_ASSERT_NOW(a_err_verdict_code, clk_i, rst_ni,
    out_valid_q && verdict_q == VERDICT_ERROR, ecode_q != ERR_NONE)
  `HSL_ASSERT_NOW(a_flags_no_error, clk_i, rst_ni,
    out_valid_q && (rb_q || re_q), verdict_q != VERDICT_ERROR && !(rb_q && re_q))

endmodule

[sim/http_status_line_parser_core_test.sv]
`timescale 1ns / 1ps
// Testbench for the HTTP status line parser core: byte stream checked against a status predictor.
module http_status_line_parser_core_test;
  import hsl_pkg::*;

  localparam int unsigned LIMIT_W     = 20;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned TEXT_ROUNDS = 8;
  localparam int unsigned TEXT_BYTES  = 235;

  typedef struct packed {
    verdict_e           verdict;
    err_e               err;
    logic [VALUE_W-1:0] major;
    logic [VALUE_W-1:0] minor;
    logic [VALUE_W-1:0] code;
    logic               rb;
    logic               re;
  } status_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [LIMIT_W-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         verdict_o;
  logic [2:0]         error_code_o;
  logic [VALUE_W-1:0] version_major_o;
  logic [VALUE_W-1:0] version_minor_o;
  logic [VALUE_W-1:0] status_value_o;
  logic               reason_begin_o;
  logic               reason_end_o;

  http_status_line_parser_core #(
    .LIMIT_WIDTH(LIMIT_W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .verdict_o      (verdict_o),
    .error_code_o   (error_code_o),
    .version_major_o(version_major_o),
    .version_minor_o(version_minor_o),
    .status_value_o (status_value_o),
    .reason_begin_o (reason_begin_o),
    .reason_end_o   (reason_end_o)
  );

  // predictor state
  phase_e             ph_q;
  logic [VALUE_W-1:0] maj_q;
  logic [VALUE_W-1:0] min_q;
  logic [VALUE_W-1:0] code_q;
  logic [20:0]        tot_q;
  logic [20:0]        line_q;
  err_e               err_q;
  logic [LIMIT_W-1:0] lim_total_q;
  logic [LIMIT_W-1:0] lim_line_q;
  logic               strict_q;

  status_word_t predicted_status[$];
  int           mismatches;
  int           idle_pct;
  int unsigned  stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void reset_parser();
    ph_q        = PH_START;
    maj_q       = '0;
    min_q       = '0;
    code_q      = '0;
    tot_q       = '0;
    line_q      = '0;
    err_q       = ERR_NONE;
    lim_total_q = TOTAL_LIMIT_RESET[LIMIT_W-1:0];
    lim_line_q  = LINE_LIMIT_RESET[LIMIT_W-1:0];
    strict_q    = 1'b0;
  endfunction

  function automatic status_word_t parse_byte(logic [7:0] c);
    status_word_t       r;
    err_e               e;
    logic               dig;
    logic [VALUE_W-1:0] d;
    r.verdict = VERDICT_MORE;
    r.rb      = 1'b0;
    r.re      = 1'b0;
    e         = ERR_NONE;
    dig       = (c >= CH_ZERO) && (c <= CH_NINE);
    d         = {6'd0, c - CH_ZERO};
    if (err_q != ERR_NONE) begin
      r.verdict = VERDICT_ERROR;
    end else begin
      tot_q = tot_q + 21'd1;
      if (tot_q > {1'b0, lim_total_q}) begin
        e = ERR_OVERFLOW;
      end else begin
        line_q = line_q + 21'd1;
        if (line_q > {1'b0, lim_line_q}) e = ERR_OVERFLOW;
      end
      if (e == ERR_NONE) begin
        case (ph_q)
          PH_START: begin
            if (c == CH_H) ph_q = PH_H;
            else if (c != CH_CR && c != CH_LF) e = ERR_CONSTANT;
          end
          PH_H: begin
            if (strict_q && c != CH_T) e = ERR_STRICT;
            else ph_q = PH_HT;
          end
          PH_HT: begin
            if (strict_q && c != CH_T) e = ERR_STRICT;
            else ph_q = PH_HTT;
          end
          PH_HTT: begin
            if (strict_q && c != CH_P) e = ERR_STRICT;
            else ph_q = PH_HTTP;
          end
          PH_HTTP: begin
            if (strict_q && c != CH_SLASH) e = ERR_STRICT;
            else ph_q = PH_FIRST_MAJOR;
          end
          PH_FIRST_MAJOR: begin
            if (!dig) begin
              e = ERR_VERSION;
            end else begin
              maj_q = d;
              ph_q  = PH_MAJOR;
            end
          end
          PH_MAJOR: begin
            if (c == CH_DOT) begin
              ph_q = PH_FIRST_MINOR;
            end else if (!dig) begin
              e = ERR_VERSION;
            end else begin
              maj_q = maj_q * 14'd10 + d;
              if (maj_q > VALUE_MAX) e = ERR_VERSION;
            end
          end
          PH_FIRST_MINOR: begin
            if (!dig) begin
              e = ERR_VERSION;
            end else begin
              min_q = d;
              ph_q  = PH_MINOR;
            end
          end
          PH_MINOR: begin
            if (c == CH_SP) begin
              ph_q = PH_FIRST_CODE;
            end else if (!dig) begin
              e = ERR_VERSION;
            end else begin
              min_q = min_q * 14'd10 + d;
              if (min_q > VALUE_MAX) e = ERR_VERSION;
            end
          end
          PH_FIRST_CODE: begin
            if (dig) begin
              code_q = d;
              ph_q   = PH_CODE;
            end else if (c != CH_SP) begin
              e = ERR_STATUS;
            end
          end
          PH_CODE: begin
            if (dig) begin
              code_q = code_q * 14'd10 + d;
              if (code_q > VALUE_MAX) e = ERR_STATUS;
            end else if (c == CH_SP) begin
              ph_q = PH_REASON_START;
            end else if (c == CH_CR) begin
              ph_q = PH_ALMOST_DONE;
            end else if (c == CH_LF) begin
              ph_q      = PH_DONE;
              r.verdict = VERDICT_DONE;
            end else begin
              e = ERR_STATUS;
            end
          end
          PH_REASON_START: begin
            if (c == CH_CR) begin
              ph_q = PH_ALMOST_DONE;
            end else if (c == CH_LF) begin
              ph_q      = PH_DONE;
              r.verdict = VERDICT_DONE;
            end else begin
              ph_q = PH_REASON;
              r.rb = 1'b1;
            end
          end
          PH_REASON: begin
            if (c == CH_CR) begin
              ph_q = PH_ALMOST_DONE;
              r.re = 1'b1;
            end else if (c == CH_LF) begin
              ph_q      = PH_DONE;
              r.re      = 1'b1;
              r.verdict = VERDICT_DONE;
            end
          end
          PH_ALMOST_DONE: begin
            if (strict_q && c != CH_LF) begin
              e = ERR_STRICT;
            end else begin
              ph_q      = PH_DONE;
              r.verdict = VERDICT_DONE;
            end
          end
          default: e = ERR_STATE;
        endcase
      end
      if (e != ERR_NONE) begin
        err_q     = e;
        r.verdict = VERDICT_ERROR;
        r.rb      = 1'b0;
        r.re      = 1'b0;
      end
    end
    r.err   = err_q;
    r.major = maj_q;
    r.minor = min_q;
    r.code  = code_q;
    return r;
  endfunction

  // any byte that keeps the parser inside the reason text
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    data_byte_i <= b;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted_status.push_back(parse_byte(b));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (predicted_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [LIMIT_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAX_TOTAL: lim_total_q = val;
      CFG_MAX_LINE:  lim_line_q  = val;
      CFG_STRICT:    strict_q    = val[0];
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // leading CR/LF, strict letters, 999 in every number, extra space before the code
  task automatic test_line_prefix();
    string s;
    s = "HTTP/0999.0999  0999 ";
    cfg_write(CFG_MAX_TOTAL, '1);
    cfg_write(CFG_MAX_LINE, LINE_LIMIT_RESET[LIMIT_W-1:0]);
    cfg_write(CFG_STRICT, LIMIT_W'(1));
    cfg_write(CFG_UNUSED, LIMIT_W'($urandom));
    cfg_close();
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_LF);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic test_reason_text();
    for (int r = 0; r < TEXT_ROUNDS; r++) begin
      drain_results();
      cfg_write(CFG_STRICT, LIMIT_W'($urandom_range(1)));
      if ($urandom_range(1)) cfg_write(CFG_MAX_TOTAL, '1);
      else cfg_write(CFG_MAX_TOTAL, LIMIT_W'(tot_q + 2100 + $urandom_range(5000)));
      if ($urandom_range(1)) cfg_write(CFG_MAX_LINE, '1);
      else cfg_write(CFG_MAX_LINE, LIMIT_W'(line_q + 2100 + $urandom_range(5000)));
      cfg_close();
      idle_pct = (r == 3) ? 0 : 13;
      repeat (TEXT_BYTES) send_byte(text_byte());
    end
    idle_pct = 13;
  endtask

  // one way out of the reason text per run: an overflow or one of the line endings
  task automatic test_line_end();
    int unsigned        how;
    logic [20:0]        base;
    logic [LIMIT_W-1:0] lim;
    drain_results();
    how = $urandom_range(5);
    cfg_write(CFG_STRICT, LIMIT_W'($urandom_range(1)));
    if (how < 2) begin
      base = (how == 0) ? tot_q : line_q;
      case ($urandom_range(3))
        0:       lim = '0;
        1:       lim = base[LIMIT_W-1:0];
        2:       lim = LIMIT_W'(base + 1);
        default: lim = LIMIT_W'(base + 3);
      endcase
      if (how == 0) cfg_write(CFG_MAX_TOTAL, lim);
      else cfg_write(CFG_MAX_LINE, lim);
    end
    cfg_close();
    case (how)
      0, 1: repeat (6) send_byte(text_byte());
      2: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      3: send_byte(CH_LF);
      4: begin
        send_byte(CH_CR);
        send_byte(text_byte());
      end
      default: begin
        send_byte(CH_CR);
        send_byte(8'($urandom_range(255)));
      end
    endcase
    repeat (3) send_byte(8'($urandom_range(255)));
  endtask

  // zero limits must not disturb a stored error
  task automatic test_sticky_error();
    drain_results();
    cfg_write(CFG_MAX_TOTAL, '0);
    cfg_write(CFG_MAX_LINE, '0);
    cfg_write(CFG_STRICT, '0);
    cfg_close();
    repeat (40) send_byte(8'($urandom_range(255)));
  endtask

  always @(posedge clk_i) begin : check_proc
    status_word_t want;
    logic         bad;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_status.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected word: v=%0d e=%0d", verdict_o, error_code_o);
        end else begin
          want = predicted_status.pop_front();
          bad  = (verdict_o !== want.verdict) || (error_code_o !== want.err) ||
                 (version_major_o !== want.major) || (version_minor_o !== want.minor) ||
                 (status_value_o !== want.code) || (reason_begin_o !== want.rb) ||
                 (reason_end_o !== want.re);
          if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch exp v=%0d e=%0d maj=%0d min=%0d code=%0d rb=%0b re=%0b",
                       want.verdict, want.err, want.major, want.minor, want.code,
                       want.rb, want.re, "\n         got v=%0d e=%0d maj=%0d min=%0d ",
                       verdict_o, error_code_o, version_major_o, version_minor_o,
                       "code=%0d rb=%0b re=%0b", status_value_o, reason_begin_o,
                       reason_end_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_MAX_TOTAL;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    out_ready_i  = 1'b0;
    mismatches   = 0;
    idle_pct     = 13;
    stall_cycles = 0;
    reset_parser();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_line_prefix();
    test_reason_text();
    test_line_end();
    test_sticky_error();
    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && predicted_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
